@@ src/slsf_pkg.sv @@
// sinusoid least-squares fit: shared constants, widths and the cordic angle table
// no dependencies
package slsf_pkg;

    localparam int MAX_SAMPLES  = 4096;
    localparam int CORDIC_STEPS = 16;

    localparam int CNT_W     = 13;
    localparam int SUM_W     = 28;
    localparam int SQ_W      = 43;
    localparam int XP_W      = 44;
    localparam int CNT_LIMIT = (MAX_SAMPLES < 8191) ? MAX_SAMPLES : 8191;

    localparam int OP_W      = 48;
    localparam int PROD_W    = 2 * OP_W;
    localparam int MUL_CNT_W = $clog2(OP_W);
    localparam int SHIFT_MAX = 31;
    localparam int DIV_W     = PROD_W + SHIFT_MAX;
    localparam int DIV_CNT_W = $clog2(DIV_W);
    localparam int REM_W     = 64;
    localparam int QUO_W     = 42;

    localparam logic [4:0] SHIFT_GAIN = 5'd31;
    localparam logic [4:0] SHIFT_OFFS = 5'd16;

    localparam logic [QUO_W-1:0] QCAP = QUO_W'(64'd1 << 40);

    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [OP_W-1:0]   t_oper;

    function automatic logic [29:0] atan_turn(input logic [4:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:    v = 30'd536870912;
            5'd1:    v = 30'd316933406;
            5'd2:    v = 30'd167458907;
            5'd3:    v = 30'd85004756;
            5'd4:    v = 30'd42667331;
            5'd5:    v = 30'd21354465;
            5'd6:    v = 30'd10679838;
            5'd7:    v = 30'd5340245;
            5'd8:    v = 30'd2670163;
            5'd9:    v = 30'd1335087;
            5'd10:   v = 30'd667544;
            5'd11:   v = 30'd333772;
            5'd12:   v = 30'd166886;
            5'd13:   v = 30'd83443;
            5'd14:   v = 30'd41722;
            5'd15:   v = 30'd20861;
            5'd16:   v = 30'd10430;
            5'd17:   v = 30'd5215;
            5'd18:   v = 30'd2608;
            5'd19:   v = 30'd1304;
            5'd20:   v = 30'd652;
            5'd21:   v = 30'd326;
            5'd22:   v = 30'd163;
            5'd23:   v = 30'd81;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

@@ src/slsf_if.sv @@
// sample and result channels with valid/ready handshake
// no dependencies
interface slsf_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] field_x;
    logic signed [15:0] field_y;
    logic [15:0]        sample_time;
    logic               last_sample;
    modport source (output valid, field_x, field_y, sample_time, last_sample, input ready);
    modport sink   (input valid, field_x, field_y, sample_time, last_sample, output ready);
endinterface

interface slsf_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] x_gain;
    logic signed [31:0] x_offset;
    logic signed [31:0] y_gain;
    logic signed [31:0] y_offset;
    logic               x_singular;
    logic               y_singular;
    modport source (output valid, x_gain, x_offset, y_gain, y_offset, x_singular, y_singular,
                    input ready);
    modport sink   (input valid, x_gain, x_offset, y_gain, y_offset, x_singular, y_singular,
                    output ready);
endinterface

@@ src/slsf_cordic.sv @@
// iterative rotation-mode cordic, one micro-rotation per cycle
// depends on slsf_pkg
module slsf_cordic import slsf_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [31:0]        i_phase,
    output logic               o_done,
    output logic signed [15:0] o_cos,
    output logic signed [15:0] o_sin
);

    logic signed [19:0] r_x, r_y;
    logic signed [33:0] r_z;
    logic [4:0]         r_i;
    logic               r_busy, r_done, r_flip;
    logic [1:0]         quad;
    logic               flip;
    logic [31:0]        ph;
    logic signed [19:0] shx, shy, fx, fy;
    logic signed [33:0] ang;

    assign quad = i_phase[31:30];
    assign flip = (quad == 2'd1) || (quad == 2'd2);
    assign ph   = flip ? (i_phase + 32'h8000_0000) : i_phase;
    assign shx  = r_x >>> r_i;
    assign shy  = r_y >>> r_i;
    assign ang  = signed'({4'b0, atan_turn(r_i)});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_flip <= flip;
                r_z    <= signed'({{2{ph[31]}}, ph});
                r_x    <= 20'sd19898;
                r_y    <= 20'sd0;
                r_i    <= 5'd0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (!r_z[33]) begin
                    r_x <= r_x - shy;
                    r_y <= r_y + shx;
                    r_z <= r_z - ang;
                end else begin
                    r_x <= r_x + shy;
                    r_y <= r_y - shx;
                    r_z <= r_z + ang;
                end
                r_i <= r_i + 5'd1;
                if (r_i == 5'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign fx = r_flip ? -r_x : r_x;
    assign fy = r_flip ? -r_y : r_y;

    always_comb begin
        if (fx > 20'sd32767)       o_cos = 16'sd32767;
        else if (fx < -20'sd32767) o_cos = -16'sd32767;
        else                       o_cos = fx[15:0];
        if (fy > 20'sd32767)       o_sin = 16'sd32767;
        else if (fy < -20'sd32767) o_sin = -16'sd32767;
        else                       o_sin = fy[15:0];
    end

    assign o_done = r_done;

endmodule

@@ src/slsf_mul.sv @@
// serial shift-and-add signed multiplier, one multiplier bit per cycle
// depends on slsf_pkg
module slsf_mul import slsf_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_oper i_a,
    input  t_oper i_b,
    output logic  o_done,
    output t_prod o_prod
);

    logic [PROD_W-1:0]    r_acc, r_a;
    logic [OP_W-1:0]      r_b;
    logic [MUL_CNT_W-1:0] r_cnt;
    logic                 r_neg, r_busy, r_done;
    logic [OP_W-1:0]      mag_a, mag_b;

    assign mag_a = i_a[OP_W-1] ? OP_W'(-i_a) : OP_W'(i_a);
    assign mag_b = i_b[OP_W-1] ? OP_W'(-i_b) : OP_W'(i_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_acc  <= '0;
                r_a    <= {{(PROD_W-OP_W){1'b0}}, mag_a};
                r_b    <= mag_b;
                r_neg  <= i_a[OP_W-1] ^ i_b[OP_W-1];
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_b[0]) r_acc <= r_acc + r_a;
                r_a   <= r_a << 1;
                r_b   <= r_b >> 1;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == MUL_CNT_W'(OP_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_prod = r_neg ? -signed'(r_acc) : signed'(r_acc);
    assign o_done = r_done;

endmodule

@@ src/slsf_div.sv @@
// restoring divider, rounded q16.16 quotient with saturation
// depends on slsf_pkg
module slsf_div import slsf_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  t_prod              i_num,
    input  t_prod              i_den,
    input  logic [4:0]         i_shift,
    output logic               o_done,
    output logic signed [31:0] o_quot
);

    logic [DIV_W-1:0]     r_sh;
    logic [REM_W-1:0]     r_rem, r_d;
    logic [QUO_W-1:0]     r_q;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_neg, r_busy, r_done;
    logic [PROD_W-1:0]    mag_n, mag_d;
    logic [REM_W-1:0]     rem1, rem2;
    logic [QUO_W-1:0]     q1;
    logic                 up;
    logic [QUO_W:0]       qf;

    assign mag_n = i_num[PROD_W-1] ? PROD_W'(-i_num) : PROD_W'(i_num);
    assign mag_d = i_den[PROD_W-1] ? PROD_W'(-i_den) : PROD_W'(i_den);

    always_comb begin
        rem1 = {r_rem[REM_W-2:0], r_sh[DIV_W-1]};
        q1   = {r_q[QUO_W-2:0], 1'b0};
        if (rem1 >= r_d) begin
            rem1  = rem1 - r_d;
            q1[0] = 1'b1;
        end
        if (q1 > QCAP) q1 = QCAP;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_sh   <= {{SHIFT_MAX{1'b0}}, mag_n} << i_shift;
                r_d    <= mag_d[REM_W-1:0];
                r_rem  <= '0;
                r_q    <= '0;
                r_neg  <= i_num[PROD_W-1] ^ i_den[PROD_W-1];
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= rem1;
                r_q   <= q1;
                r_sh  <= r_sh << 1;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign rem2 = {r_rem[REM_W-2:0], 1'b0};
    assign up   = (rem2 >= r_d);
    assign qf   = {1'b0, r_q} + (QUO_W+1)'(up);

    always_comb begin
        if (r_neg) begin
            if (qf > (QUO_W+1)'(64'd2147483648)) o_quot = 32'sh8000_0000;
            else                                  o_quot = -signed'(qf[31:0]);
        end else begin
            if (qf > (QUO_W+1)'(64'd2147483647)) o_quot = 32'sh7fff_ffff;
            else                                  o_quot = signed'(qf[31:0]);
        end
    end

    assign o_done = r_done;

endmodule

@@ src/sinusoid_least_squares_fit.sv @@
// Fits x = gain*cos(wt) + offset and y = gain*sin(wt) + offset over a run of samples and
// reports both fits on the sample marked last. One sample at a time: a sample taken while
// the sums are full is not accumulated, while any other sample goes through the
// one-step-per-cycle cordic and the four shared products before the next is taken.
// A last sample adds the solve, run on the serial multiplier and the serial divider.
// A finished result waits in the output register while new samples are taken.
// depends on slsf_pkg, slsf_if, slsf_cordic, slsf_mul, slsf_div
module sinusoid_least_squares_fit import slsf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    slsf_in_if.sink     i_in,
    slsf_out_if.source  o_out
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ROT  = 3'd1;
    localparam logic [2:0] S_ACC  = 3'd2;
    localparam logic [2:0] S_SMUL = 3'd3;
    localparam logic [2:0] S_CHK  = 3'd4;
    localparam logic [2:0] S_SDIV = 3'd5;
    localparam logic [2:0] S_EMIT = 3'd6;

    logic [2:0]              r_state;
    logic [31:0]             r_omega, r_phase;
    logic signed [15:0]      r_fx, r_fy;
    logic                    r_last, r_cgo, r_go, r_sys, r_dj;
    logic [2:0]              r_k, r_j;
    logic signed [31:0]      r_prod;
    logic [CNT_W-1:0]        r_cnt;
    logic signed [SUM_W-1:0] r_sc, r_sx, r_ss, r_sy;
    logic signed [SQ_W-1:0]  r_scc, r_sss;
    logic signed [XP_W-1:0]  r_scx, r_ssy;
    t_prod                   r_t, r_det, r_numg, r_numo;
    logic signed [31:0]      r_gx, r_ox, r_gy, r_oy;
    logic                    r_sgx, r_sgy;
    logic                    r_ovalid;
    logic signed [31:0]      r_o_gx, r_o_ox, r_o_gy, r_o_oy;
    logic                    r_o_sx, r_o_sy;

    logic                    accept, room;
    logic                    c_done, m_done, d_done;
    logic signed [15:0]      c_cos, c_sin;
    logic signed [15:0]      pa, pb;
    t_oper                   op_n, op_sc, op_scc, op_scv, op_sv, m_a, m_b;
    t_prod                   m_prod;
    t_prod                   d_num;
    logic [4:0]              d_shift;
    logic signed [31:0]      d_quot;

    assign accept      = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == S_IDLE);
    assign room        = (r_cnt < CNT_W'(CNT_LIMIT));

    slsf_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_cgo),
        .i_phase (r_phase),
        .o_done  (c_done),
        .o_cos   (c_cos),
        .o_sin   (c_sin)
    );

    always_comb begin
        case (r_k)
            3'd0:    begin pa = c_cos; pb = c_cos; end
            3'd1:    begin pa = c_cos; pb = r_fx;  end
            3'd2:    begin pa = c_sin; pb = c_sin; end
            3'd3:    begin pa = c_sin; pb = r_fy;  end
            default: begin pa = c_sin; pb = r_fy;  end
        endcase
    end

    assign op_n   = signed'({{(OP_W-CNT_W){1'b0}}, r_cnt});
    assign op_sc  = r_sys ? OP_W'(r_ss)  : OP_W'(r_sc);
    assign op_scc = r_sys ? OP_W'(r_sss) : OP_W'(r_scc);
    assign op_scv = r_sys ? OP_W'(r_ssy) : OP_W'(r_scx);
    assign op_sv  = r_sys ? OP_W'(r_sy)  : OP_W'(r_sx);

    always_comb begin
        case (r_j)
            3'd0:    begin m_a = op_scc; m_b = op_n;   end
            3'd1:    begin m_a = op_sc;  m_b = op_sc;  end
            3'd2:    begin m_a = op_n;   m_b = op_scv; end
            3'd3:    begin m_a = op_sc;  m_b = op_sv;  end
            3'd4:    begin m_a = op_scc; m_b = op_sv;  end
            default: begin m_a = op_sc;  m_b = op_scv; end
        endcase
    end

    slsf_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_go && (r_state == S_SMUL)),
        .i_a     (m_a),
        .i_b     (m_b),
        .o_done  (m_done),
        .o_prod  (m_prod)
    );

    assign d_num   = r_dj ? r_numo : r_numg;
    assign d_shift = r_dj ? SHIFT_OFFS : SHIFT_GAIN;

    slsf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_go && (r_state == S_SDIV)),
        .i_num   (d_num),
        .i_den   (r_det),
        .i_shift (d_shift),
        .o_done  (d_done),
        .o_quot  (d_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_omega <= '0;
        end else if (i_cfg_we) begin
            r_omega <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cgo    <= 1'b0;
            r_go     <= 1'b0;
            r_ovalid <= 1'b0;
            r_cnt    <= '0;
            r_sc     <= '0;
            r_sx     <= '0;
            r_ss     <= '0;
            r_sy     <= '0;
            r_scc    <= '0;
            r_sss    <= '0;
            r_scx    <= '0;
            r_ssy    <= '0;
        end else begin
            r_cgo <= 1'b0;
            if (o_out.valid && o_out.ready && (r_state != S_EMIT)) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_fx    <= i_in.field_x;
                        r_fy    <= i_in.field_y;
                        r_last  <= i_in.last_sample;
                        r_phase <= 32'(r_omega * i_in.sample_time);
                        if (room) begin
                            r_cgo   <= 1'b1;
                            r_state <= S_ROT;
                        end else if (i_in.last_sample) begin
                            r_sys   <= 1'b0;
                            r_j     <= 3'd0;
                            r_go    <= 1'b1;
                            r_state <= S_SMUL;
                        end
                    end
                end
                S_ROT: begin
                    if (c_done) begin
                        r_k     <= 3'd0;
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    r_prod <= pa * pb;
                    r_k    <= r_k + 3'd1;
                    case (r_k)
                        3'd0: begin
                            r_cnt <= r_cnt + 1'b1;
                            r_sc  <= r_sc + SUM_W'(c_cos);
                            r_ss  <= r_ss + SUM_W'(c_sin);
                            r_sx  <= r_sx + SUM_W'(r_fx);
                            r_sy  <= r_sy + SUM_W'(r_fy);
                        end
                        3'd1:    r_scc <= r_scc + SQ_W'(r_prod);
                        3'd2:    r_scx <= r_scx + XP_W'(r_prod);
                        3'd3:    r_sss <= r_sss + SQ_W'(r_prod);
                        default: begin
                            r_ssy <= r_ssy + XP_W'(r_prod);
                            if (r_last) begin
                                r_sys   <= 1'b0;
                                r_j     <= 3'd0;
                                r_go    <= 1'b1;
                                r_state <= S_SMUL;
                            end else begin
                                r_state <= S_IDLE;
                            end
                        end
                    endcase
                end
                S_SMUL: begin
                    r_go <= 1'b0;
                    if (m_done) begin
                        case (r_j)
                            3'd1:    r_det  <= r_t - m_prod;
                            3'd3:    r_numg <= r_t - m_prod;
                            3'd5:    r_numo <= r_t - m_prod;
                            default: r_t    <= m_prod;
                        endcase
                        if (r_j == 3'd5) begin
                            r_state <= S_CHK;
                        end else begin
                            r_j  <= r_j + 3'd1;
                            r_go <= 1'b1;
                        end
                    end
                end
                S_CHK: begin
                    if (r_det == '0) begin
                        if (r_sys) begin
                            r_gy <= '0; r_oy <= '0; r_sgy <= 1'b1;
                            r_state <= S_EMIT;
                        end else begin
                            r_gx <= '0; r_ox <= '0; r_sgx <= 1'b1;
                            r_sys   <= 1'b1;
                            r_j     <= 3'd0;
                            r_go    <= 1'b1;
                            r_state <= S_SMUL;
                        end
                    end else begin
                        r_dj    <= 1'b0;
                        r_go    <= 1'b1;
                        r_state <= S_SDIV;
                    end
                end
                S_SDIV: begin
                    r_go <= 1'b0;
                    if (d_done) begin
                        if (!r_dj) begin
                            if (r_sys) r_gy <= d_quot;
                            else       r_gx <= d_quot;
                            r_dj <= 1'b1;
                            r_go <= 1'b1;
                        end else if (r_sys) begin
                            r_oy    <= d_quot;
                            r_sgy   <= 1'b0;
                            r_state <= S_EMIT;
                        end else begin
                            r_ox    <= d_quot;
                            r_sgx   <= 1'b0;
                            r_sys   <= 1'b1;
                            r_j     <= 3'd0;
                            r_go    <= 1'b1;
                            r_state <= S_SMUL;
                        end
                    end
                end
                S_EMIT: begin
                    if (!r_ovalid || o_out.ready) begin
                        r_ovalid <= 1'b1;
                        r_o_gx   <= r_gx;
                        r_o_ox   <= r_ox;
                        r_o_gy   <= r_gy;
                        r_o_oy   <= r_oy;
                        r_o_sx   <= r_sgx;
                        r_o_sy   <= r_sgy;
                        r_cnt    <= '0;
                        r_sc     <= '0;
                        r_sx     <= '0;
                        r_ss     <= '0;
                        r_sy     <= '0;
                        r_scc    <= '0;
                        r_sss    <= '0;
                        r_scx    <= '0;
                        r_ssy    <= '0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid      = r_ovalid;
    assign o_out.x_gain     = r_o_gx;
    assign o_out.x_offset   = r_o_ox;
    assign o_out.y_gain     = r_o_gy;
    assign o_out.y_offset   = r_o_oy;
    assign o_out.x_singular = r_o_sx;
    assign o_out.y_singular = r_o_sy;

endmodule

@@ src/slsf_checker.sv @@
// port-level checks for the sinusoid fit, bound to the top level
// depends on slsf_pkg, sinusoid_least_squares_fit
module slsf_checker import slsf_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_x_singular,
    input logic [31:0] i_x_gain
);

    // a result is held until its transaction completes
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped before transaction");

    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // a sample transaction never raises a result directly
    a_no_result_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !$rose(i_out_valid))
        else $error("result right after sample");

    a_result_from_solve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result without solve");

    a_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_x_singular |-> i_x_gain == 32'd0)
        else $error("singular fit with nonzero gain");

endmodule

bind sinusoid_least_squares_fit slsf_checker u_slsf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_x_singular (o_out.x_singular),
    .i_x_gain     (o_out.x_gain)
);
